>>> rtl/core/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher block.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int KEY_LENGTH = 10;
  localparam int KEY_LEN_EFF = (KEY_LENGTH < 1) ? 1 : ((KEY_LENGTH > 16) ? 16 : KEY_LENGTH);
  localparam int KEY_IDX_W = 4;
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_LAST = KEY_IDX_W'(KEY_LEN_EFF - 1);

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(1);
  localparam logic [63:0] KEY_LOW_RESET = 64'h0706050403020100;
  localparam logic [63:0] KEY_HIGH_RESET = 64'h0000000000000908;

  localparam logic KIND_REKEY = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K_RDN,
    ST_K_RDJ,
    ST_K_WRN,
    ST_K_WRJ,
    ST_P_RDJ,
    ST_P_WRI,
    ST_P_WRJ,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_K_RDN,
    OP_K_RDJ,
    OP_K_WRN,
    OP_K_WRJ,
    OP_P_RDJ,
    OP_P_WRI,
    OP_P_WRJ,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic ksa_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/rc4_ctrl.sv
// Sequencer for key scheduling and keystream steps of the RC4 block.
`timescale 1ns / 1ps

module rc4_ctrl import rc4_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_kind == KIND_DATA) ? ST_P_RDJ : ST_K_RDN;
        end
      end
      ST_K_RDN: state_next = ST_K_RDJ;
      ST_K_RDJ: state_next = ST_K_WRN;
      ST_K_WRN: state_next = ST_K_WRJ;
      ST_K_WRJ: state_next = status.ksa_last ? ST_DONE : ST_K_RDN;
      ST_P_RDJ: state_next = ST_P_WRI;
      ST_P_WRI: state_next = ST_P_WRJ;
      ST_P_WRJ: state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd.op = OP_IDLE;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.op = in_valid ? OP_ACCEPT : OP_IDLE;
      end
      ST_K_RDN: cmd.op = OP_K_RDN;
      ST_K_RDJ: cmd.op = OP_K_RDJ;
      ST_K_WRN: cmd.op = OP_K_WRN;
      ST_K_WRJ: cmd.op = OP_K_WRJ;
      ST_P_RDJ: cmd.op = OP_P_RDJ;
      ST_P_WRI: cmd.op = OP_P_WRI;
      ST_P_WRJ: cmd.op = OP_P_WRJ;
      ST_DONE:  cmd.op = status.out_free ? OP_FINISH : OP_IDLE;
      default:  cmd.op = OP_IDLE;
    endcase
  end

  a_data_starts_prga: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && in_kind == KIND_DATA) |=> state == ST_P_RDJ)
    else $error("data item did not enter the keystream sequence");

  a_stall_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input accepted while an item is in work");

  a_ksa_loops: assert property (@(posedge clk) disable iff (rst)
    (state == ST_K_WRJ && !status.ksa_last) |=> state == ST_K_RDN)
    else $error("key scheduling left its loop early");

endmodule

>>> rtl/core/rc4_datapath.sv
// Permutation memory, indices, key registers and result register of the RC4 block.
`timescale 1ns / 1ps

module rc4_datapath import rc4_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic                 kind,
  input  logic [7:0]           data_in,
  input  logic                 last_in,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           data_out,
  output logic                 last_out,
  output logic                 rekey_done
);

  logic [7:0] mem [256];
  logic [255:0] vld;
  logic [7:0] rd_q;
  logic rvld_q;
  logic [7:0] raddr_q;
  logic keyed;

  logic mem_we;
  logic mem_re;
  logic [7:0] mem_waddr;
  logic [7:0] mem_wdata;
  logic [7:0] mem_raddr;
  logic [7:0] rdata;

  logic [63:0] key_low;
  logic [63:0] key_high;
  logic [127:0] key_all;
  logic [KEY_IDX_W-1:0] kidx;
  logic [7:0] key_b;

  logic [7:0] index_i;
  logic [7:0] index_j;
  logic [7:0] si;
  logic [7:0] sj;
  logic tj_hit;
  logic item_kind;
  logic [7:0] item_data;
  logic item_last;

  logic [7:0] i_inc;
  logic [7:0] j_ksa;
  logic [7:0] j_prga;
  logic [7:0] t_addr;
  logic [7:0] ks;
  logic out_take;

  // Entries never written since the last rekey read as identity, and as zero before any rekey.
  assign rdata = rvld_q ? rd_q : (keyed ? raddr_q : 8'h00);

  assign key_all = {key_high, key_low};
  assign key_b = key_all[{kidx, 3'b000} +: 8];
  assign i_inc = index_i + 8'd1;
  assign j_ksa = index_j + rdata + key_b;
  assign j_prga = index_j + rdata;
  assign t_addr = si + sj;
  // The keystream read overlaps the write of S[j], so when t equals j the byte is taken from the swap holding register.
  assign ks = tj_hit ? si : rdata;

  assign out_take = out_valid && !out_stall;
  assign status.out_free = !out_valid || !out_stall;
  assign status.ksa_last = (index_i == 8'hFF);

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = index_i;
    mem_wdata = rdata;
    mem_raddr = index_i;
    case (cmd.op)
      OP_ACCEPT: begin
        mem_re = (kind == KIND_DATA);
        mem_raddr = i_inc;
      end
      OP_K_RDN: begin
        mem_re = 1'b1;
        mem_raddr = index_i;
      end
      OP_K_RDJ: begin
        mem_re = 1'b1;
        mem_raddr = j_ksa;
      end
      OP_P_RDJ: begin
        mem_re = 1'b1;
        mem_raddr = j_prga;
      end
      OP_K_WRN, OP_P_WRI: begin
        mem_we = 1'b1;
        mem_waddr = index_i;
        mem_wdata = rdata;
      end
      OP_K_WRJ: begin
        mem_we = 1'b1;
        mem_waddr = index_j;
        mem_wdata = si;
      end
      OP_P_WRJ: begin
        mem_we = 1'b1;
        mem_waddr = index_j;
        mem_wdata = si;
        mem_re = 1'b1;
        mem_raddr = t_addr;
      end
      default: begin
        mem_we = 1'b0;
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
      raddr_q <= mem_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rvld_q <= 1'b0;
      keyed <= 1'b0;
    end else begin
      if (mem_re) begin
        rvld_q <= vld[mem_raddr];
      end
      if (cmd.op == OP_ACCEPT && kind == KIND_REKEY) begin
        vld <= '0;
        keyed <= 1'b1;
      end else if (mem_we) begin
        vld[mem_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= KEY_LOW_RESET;
      key_high <= KEY_HIGH_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_KEY_LOW) begin
        key_low <= cfg_data;
      end else if (cfg_index == REG_KEY_HIGH) begin
        key_high <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_i <= 8'h00;
      index_j <= 8'h00;
      kidx <= '0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          if (kind == KIND_DATA) begin
            index_i <= i_inc;
          end else begin
            index_i <= 8'h00;
            index_j <= 8'h00;
            kidx <= '0;
          end
        end
        OP_K_RDJ: begin
          index_j <= j_ksa;
          kidx <= (kidx == KEY_IDX_LAST) ? '0 : kidx + KEY_IDX_W'(1);
        end
        OP_K_WRJ: begin
          // The byte counter wraps to zero after the last entry, which is also the final i.
          index_i <= i_inc;
          if (status.ksa_last) begin
            index_j <= 8'h00;
          end
        end
        OP_P_RDJ: begin
          index_j <= j_prga;
        end
        default: begin
          index_i <= index_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) begin
      item_kind <= kind;
      item_data <= data_in;
      item_last <= last_in;
    end
    if (cmd.op == OP_K_RDJ || cmd.op == OP_P_RDJ) begin
      si <= rdata;
    end
    if (cmd.op == OP_P_WRI) begin
      sj <= rdata;
    end
    if (cmd.op == OP_P_WRJ) begin
      tj_hit <= (t_addr == index_j);
    end
    if (cmd.op == OP_FINISH) begin
      data_out <= (item_kind == KIND_DATA) ? (item_data ^ ks) : 8'h00;
      last_out <= item_last;
      rekey_done <= (item_kind == KIND_REKEY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  a_finish_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_FINISH |-> (!out_valid || !out_stall))
    else $error("result loaded over an item not yet taken");

  a_rekey_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_ACCEPT && kind == KIND_REKEY) |=> (keyed && vld == '0 && index_j == 8'h00))
    else $error("rekey did not reset the permutation state");

  a_ksa_end_indices: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_K_WRJ && index_i == 8'hFF) |=> (index_i == 8'h00 && index_j == 8'h00))
    else $error("indices not cleared at the end of key scheduling");

endmodule

>>> rtl/core/rc4_stream_cipher.sv
// Data item: one accept step, three memory steps and one load of the result register.
// Rekey item: each of the 256 swaps takes four memory steps.
// One item is in work at a time; the next is accepted while the result waits in its register.
// Reset (rst, synchronous) clears indices, key registers to their defaults and the output valid;
// per-entry valid flops make the permutation read as all zeros at once, with no clearing pass.
`timescale 1ns / 1ps

module rc4_stream_cipher import rc4_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic [7:0]           data_in,
  input  logic                 last_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           data_out,
  output logic                 last_out,
  output logic                 rekey_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  dp_cmd_t cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rc4_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .kind       (kind),
    .data_in    (data_in),
    .last_in    (last_in),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .data_out   (data_out),
    .last_out   (last_out),
    .rekey_done (rekey_done)
  );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the RC4 stream cipher block: queued stimulus, bursty driver, checker.
`timescale 1ns / 1ps

module testbench import rc4_pkg::*;;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 550;

  typedef struct {
    logic       kind_bit;
    logic [7:0] value;
    logic       last_flag;
  } cipher_in_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last_flag;
    logic       rekey_ack;
  } cipher_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [7:0] data_in = 8'h00;
  logic last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] data_out;
  logic last_out;
  logic rekey_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = 64'h0;

  // Predictor state: permutation, generator indices and key registers.
  logic [7:0]  perm_model [0:255];
  logic [7:0]  idx_i_model;
  logic [7:0]  idx_j_model;
  logic [63:0] key_low_model;
  logic [63:0] key_high_model;

  cipher_in_t  pending_items [$];
  cipher_out_t expected_out [$];

  int mismatches = 0;
  int results_seen = 0;
  int rekeys_queued = 0;
  int bytes_queued = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  rc4_stream_cipher u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .data_in    (data_in),
    .last_in    (last_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_out   (data_out),
    .last_out   (last_out),
    .rekey_done (rekey_done),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic cipher_out_t predict_cipher(logic k, logic [7:0] d, logic l);
    cipher_out_t r;
    logic [7:0] t;
    logic [7:0] pos;
    logic [7:0] j;
    logic [63:0] word;
    int n;
    r.last_flag = l;
    if (k == KIND_REKEY) begin
      for (n = 0; n < 256; n++) perm_model[n] = n[7:0];
      j = 8'h00;
      for (n = 0; n < 256; n++) begin
        word = ((n % KEY_LEN_EFF) < 8) ? key_low_model : key_high_model;
        j = j + perm_model[n] + word[8 * ((n % KEY_LEN_EFF) % 8) +: 8];
        t = perm_model[n];
        perm_model[n] = perm_model[j];
        perm_model[j] = t;
      end
      idx_i_model = 8'h00;
      idx_j_model = 8'h00;
      r.value = 8'h00;
      r.rekey_ack = 1'b1;
    end else begin
      idx_i_model = idx_i_model + 8'd1;
      idx_j_model = idx_j_model + perm_model[idx_i_model];
      t = perm_model[idx_i_model];
      perm_model[idx_i_model] = perm_model[idx_j_model];
      perm_model[idx_j_model] = t;
      pos = perm_model[idx_i_model] + perm_model[idx_j_model];
      r.value = d ^ perm_model[pos];
      r.rekey_ack = 1'b0;
    end
    return r;
  endfunction

  function automatic void add_item(logic k, logic [7:0] v, logic l);
    cipher_in_t it;
    it.kind_bit = k;
    it.value = v;
    it.last_flag = l;
    pending_items.push_back(it);
    if (k == KIND_REKEY) rekeys_queued++;
    else bytes_queued++;
  endfunction

  function automatic logic [63:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 64'h0;
      1: return '1;
      2: return 64'h5555_5555_5555_5555;
      3: return 64'hAAAA_AAAA_AAAA_AAAA;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sampled at the falling edge so that queue updates made at the rising edge have settled.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_out.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Driver: bursts of random length from the pending queue, random gaps in between.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    cipher_in_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        kind <= it.kind_bit;
        data_in <= it.value;
        last_in <= it.last_flag;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 3);
            2: gap_left = $urandom_range(1, 8);
            default: gap_left = $urandom_range(10, 30);
          endcase
        end
      end
    end
  end

  // Monitor: checks each result, tracks register writes, predicts each accepted item.
  int stall_timer = 0;
  int stall_mode = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    cipher_out_t want;
    cipher_out_t got;
    int n;
    if (rst) begin
      for (n = 0; n < 256; n++) perm_model[n] = 8'h00;
      idx_i_model = 8'h00;
      idx_j_model = 8'h00;
      key_low_model = KEY_LOW_RESET;
      key_high_model = KEY_HIGH_RESET;
      expected_out.delete();
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        got.value = data_out;
        got.last_flag = last_out;
        got.rekey_ack = rekey_done;
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: result with nothing expected: data=%02h last=%b rekey=%b",
                     data_out, last_out, rekey_done);
        end else begin
          want = expected_out.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("tb: mismatch at result %0d: data exp %02h got %02h,",
                       results_seen, want.value, got.value);
              $display("tb:   last exp %b got %b, rekey exp %b got %b",
                       want.last_flag, got.last_flag, want.rekey_ack, got.rekey_ack);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KEY_LOW) key_low_model = cfg_data;
        else if (cfg_index == REG_KEY_HIGH) key_high_model = cfg_data;
      end
      if (in_valid && !in_stall)
        expected_out.push_back(predict_cipher(kind, data_in, last_in));

      // The receiver switches between no stall, light, heavy and periodic stalling.
      if (stall_timer == 0) begin
        stall_timer = $urandom_range(50, 300);
        stall_mode = $urandom_range(0, 3);
      end else begin
        stall_timer--;
      end
      stall_tick++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((stall_tick % 9) < 4);
      endcase
    end
  end

  initial begin
    int r;
    int n;
    int blen;
    int base;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Before any rekey the table is all zeros, so bytes pass through unchanged.
    add_item(KIND_DATA, 8'h00, 1'b0);
    add_item(KIND_DATA, 8'hFF, 1'b1);
    add_item(KIND_DATA, 8'hA5, 1'b0);
    // Rekey with the reset key; its data byte is ignored and its last flag passes.
    add_item(KIND_REKEY, 8'hFF, 1'b1);
    add_item(KIND_DATA, 8'h00, 1'b0);
    add_item(KIND_DATA, 8'hFF, 1'b0);
    add_item(KIND_DATA, 8'h00, 1'b0);
    add_item(KIND_DATA, 8'hFF, 1'b0);
    add_item(KIND_DATA, 8'h5A, 1'b0);
    add_item(KIND_DATA, 8'hC3, 1'b1);
    // A rekey in the middle of a stream restarts the generator.
    add_item(KIND_REKEY, 8'h00, 1'b0);
    add_item(KIND_DATA, 8'h00, 1'b0);
    add_item(KIND_DATA, 8'h80, 1'b0);
    add_item(KIND_DATA, 8'h01, 1'b1);
    wait_idle();

    cfg_write(REG_KEY_LOW, 64'h0);
    cfg_write(REG_KEY_HIGH, 64'h0);
    @(negedge clk);
    add_item(KIND_REKEY, 8'h00, 1'b0);
    add_item(KIND_DATA, 8'h00, 1'b0);
    add_item(KIND_DATA, 8'hFF, 1'b1);
    wait_idle();

    cfg_write(REG_KEY_LOW, '1);
    cfg_write(REG_KEY_HIGH, '1);
    @(negedge clk);
    add_item(KIND_REKEY, 8'h00, 1'b1);
    add_item(KIND_DATA, 8'h00, 1'b0);
    add_item(KIND_DATA, 8'hFF, 1'b1);
    wait_idle();

    // Writes to indexes past the two key registers must leave the key alone.
    cfg_write('1, 64'h0123_4567_89AB_CDEF);
    cfg_write(CFG_IDX_W'(2), 64'hFEDC_BA98_7654_3210);
    @(negedge clk);
    add_item(KIND_REKEY, 8'h00, 1'b0);
    add_item(KIND_DATA, 8'h3C, 1'b1);
    wait_idle();

    base = rekeys_queued + bytes_queued;
    while (rekeys_queued + bytes_queued - base < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      case (r)
        0: ;
        1, 2, 3, 4, 5: begin
          cfg_write(REG_KEY_LOW, {$urandom, $urandom});
          cfg_write(REG_KEY_HIGH, {$urandom, $urandom});
        end
        6: cfg_write(REG_KEY_LOW, pick_extreme());
        7: cfg_write(REG_KEY_HIGH, pick_extreme());
        8: cfg_write(CFG_IDX_W'($urandom_range(2, 255)), {$urandom, $urandom});
        default: begin
          cfg_write(REG_KEY_LOW, KEY_LOW_RESET);
          cfg_write(REG_KEY_HIGH, KEY_HIGH_RESET);
        end
      endcase
      @(negedge clk);
      // Mostly a rekey followed by whole buffers; now and then the old stream continues.
      if ($urandom_range(0, 9) != 0) add_item(KIND_REKEY, 8'($urandom), 1'($urandom));
      repeat ($urandom_range(1, 3)) begin
        blen = $urandom_range(1, 24);
        for (n = 0; n < blen; n++) add_item(KIND_DATA, 8'($urandom), n == blen - 1);
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 6))
          add_item(($urandom_range(0, 4) == 0) ? KIND_REKEY : KIND_DATA,
                   8'($urandom), 1'($urandom));
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (expected_out.size() != 0) mismatches++;
    $display("tb: %0d rekeys and %0d cipher bytes sent, %0d register writes, %0d results checked",
             rekeys_queued, bytes_queued, cfg_writes, results_seen);
    $display("tb: %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
